[rtl/core/assert_macros.svh]
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/speq_pkg.sv]
// Shared types and constants of the stable priority event queue.
package speq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W = 5;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic [3:0]  resource;
    logic [3:0]  system;
    logic [15:0] amount;
    logic [7:0]  status;
    logic [7:0]  prio;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

[rtl/core/speq_in_if.sv]
// Command channel of the queue: push or pop with the pushed event.
interface speq_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  in_priority;
  logic [7:0]  in_status;
  logic [15:0] in_amount;
  logic [3:0]  in_system;
  logic [3:0]  in_resource;

  modport source (output valid, command, in_priority, in_status, in_amount, in_system,
                  in_resource, input ready);
  modport sink (input valid, command, in_priority, in_status, in_amount, in_system,
                in_resource, output ready);
endinterface

[rtl/core/speq_out_if.sv]
// Result channel of the queue: status, popped event and occupancy.
interface speq_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [7:0]  out_priority;
  logic [7:0]  out_status;
  logic [15:0] out_amount;
  logic [3:0]  out_system;
  logic [3:0]  out_resource;
  logic [4:0]  occupancy;

  modport source (output valid, ok, out_priority, out_status, out_amount, out_system,
                  out_resource, occupancy, input ready);
  modport sink (input valid, ok, out_priority, out_status, out_amount, out_system,
                out_resource, occupancy, output ready);
endinterface

[rtl/core/speq_cell.sv]
// One slot of the sorted chain: holds an event and shifts toward its neighbors.
module speq_cell (
  input  logic                 clk,
  input  speq_pkg::cell_ctrl_t ctrl,
  input  logic                 occupied,
  input  speq_pkg::entry_t     left_entry,
  input  logic                 left_keep,
  input  speq_pkg::entry_t     right_entry,
  output speq_pkg::entry_t     entry,
  output logic                 keep
);
  import speq_pkg::*;

  // A stored event stays in place on a push when it ranks at or above the new one.
  assign keep = occupied && (entry.prio >= ctrl.new_entry.prio);

  always_ff @(posedge clk) begin
    if (ctrl.push && !keep) begin
      // The first cell that gives way takes the new event; later ones shift down.
      entry <= left_keep ? ctrl.new_entry : left_entry;
    end else if (ctrl.pop) begin
      entry <= right_entry;
    end
  end

endmodule

[rtl/core/stable_priority_event_queue.sv]
// Stable priority event queue built as a chain of sorted cells.
// Each accepted beat is resolved at once; its result beat appears the next cycle.
// Throughput is one beat per cycle while results are taken; cmd.ready follows res.ready.
// Push and pop work on all cells at once, so depth does not change the timing.
// Synchronous reset empties the queue and drops any pending result; no clearing pass.
`include "assert_macros.svh"

module stable_priority_event_queue (
  input logic      clk,
  input logic      rst,
  speq_in_if.sink  cmd,
  speq_out_if.source res
);
  import speq_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             push_do;
  logic             pop_do;
  cell_ctrl_t       ctrl;
  entry_t           cell_entry [QUEUE_DEPTH];
  logic             cell_keep  [QUEUE_DEPTH];

  assign cmd.ready = !res.valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign push_do   = accept && (cmd.command == CMD_PUSH) && (count != CNT_W'(QUEUE_DEPTH));
  assign pop_do    = accept && (cmd.command == CMD_POP) && (count != '0);

  always_comb begin
    ctrl.push                = push_do;
    ctrl.pop                 = pop_do;
    ctrl.new_entry.prio      = cmd.in_priority;
    ctrl.new_entry.status    = cmd.in_status;
    ctrl.new_entry.amount    = cmd.in_amount;
    ctrl.new_entry.system    = cmd.in_system;
    ctrl.new_entry.resource  = cmd.in_resource;
  end

  always_comb begin
    count_next = count;
    if (push_do) begin
      count_next = count + CNT_W'(1);
    end else if (pop_do) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_entry;
    logic   left_keep;
    entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_entry = ctrl.new_entry;
      assign left_keep  = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = ctrl.new_entry;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    speq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (CNT_W'(i) < count),
      .left_entry  (left_entry),
      .left_keep   (left_keep),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.ok           <= push_do || pop_do;
      res.occupancy    <= OCC_W'(count_next);
      res.out_priority <= pop_do ? cell_entry[0].prio     : '0;
      res.out_status   <= pop_do ? cell_entry[0].status   : '0;
      res.out_amount   <= pop_do ? cell_entry[0].amount   : '0;
      res.out_system   <= pop_do ? cell_entry[0].system   : '0;
      res.out_resource <= pop_do ? cell_entry[0].resource : '0;
    end
  end

  `SPQ_ASSERT(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
  `SPQ_ASSERT_ALWAYS(a_reset_idle, rst |=> !res.valid, "result beat pending after reset")
  `SPQ_ASSERT(a_pop_empty_fails, (accept && cmd.command == CMD_POP && count == '0) |=> !res.ok,
              "pop from empty queue reported success")
  `SPQ_ASSERT(a_push_grows, push_do |=> count == $past(count) + CNT_W'(1),
              "accepted push did not grow the queue")
  `SPQ_ASSERT(a_head_sorted, (count >= CNT_W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio),
              "head cell ranks below the next cell")

endmodule
